FILE: design/ssd_pkg.sv
// Shared widths, defaults, register indexes and controller/datapath command types.
`default_nettype none
package ssd_pkg;

  // fixed field widths
  localparam int JIDX_W    = 5;   // joint_index port width
  localparam int POS_W     = 24;  // signed coordinate width
  localparam int SQ_W      = 2 * POS_W;
  localparam int D2_W      = SQ_W + 2;  // sum of three squares
  localparam int ROOT_W    = D2_W / 2;  // step length width
  localparam int SUM_W     = 25;  // frame step sum
  localparam int CNT_W     = 5;   // joints counted
  localparam int MEAN_W    = 20;
  localparam int PERIOD_W  = 8;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // parameter defaults
  localparam int JOINTS_DEF = 25;
  localparam int WINDOW_DEF = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_JOINT_SPEED_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL_LIMIT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STANDBY_PERIOD    = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0]    JOINT_SPEED_LIMIT_RST = 20'd10000;
  localparam logic [CFG_W-1:0]    STILL_LIMIT_RST       = 20'd1500;
  localparam logic [PERIOD_W-1:0] STANDBY_PERIOD_RST    = 8'd5;

  // axis select codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic       load_in;        // latch input word, read stored position
    logic [1:0] axis;
    logic       diff;           // register |cur - prev| for axis
    logic       mul;            // square it
    logic       acc;            // add into squared distance
    logic       sqrt_start;
    logic       pos_write;
    logic       step_update;    // sum and count the step
    logic       div_step_start; // step_sum / count
    logic       hold_update;
    logic       win_read;
    logic       win_update;
    logic       win_mean;       // register window sum / WINDOW
    logic       finish;         // load output word, standby, clear frame
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic last;
    logic count_zero;
    logic sqrt_busy;
    logic div_busy;
  } dp_st_t;

endpackage
`default_nettype wire

FILE: design/ssd_sqrt.sv
// Iterative integer square root, one result bit per cycle, rounded down.
`default_nettype none
module ssd_sqrt
  import ssd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [D2_W-1:0]   radicand,
  output logic                   busy,
  output logic [ROOT_W-1:0]      root
);

  localparam int ITER_W = $clog2(ROOT_W + 1);

  logic [D2_W-1:0]   rad;
  logic [ROOT_W+1:0] rem;
  logic [ITER_W-1:0] iter;

  logic [ROOT_W+3:0] shifted;
  logic [ROOT_W+3:0] trial;
  logic [ROOT_W+3:0] sub;
  logic              ge;

  assign shifted = {rem, rad[D2_W-1:D2_W-2]};
  assign trial   = {2'b00, root, 2'b01};
  assign sub     = shifted - trial;
  assign ge      = shifted >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= ITER_W'(ROOT_W);
    end else if (busy) begin
      iter <= iter - 1'b1;
      if (iter == ITER_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[D2_W-3:0], 2'b00};
      rem  <= ge ? sub[ROOT_W+1:0] : shifted[ROOT_W+1:0];
      root <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

FILE: design/ssd_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ssd_div
  import ssd_pkg::*;
#(
  parameter int N = SUM_W,
  parameter int D = CNT_W
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [N-1:0] dividend,
  input  wire logic [D-1:0] divisor,
  output logic              busy,
  output logic [N-1:0]      quotient
);

  localparam int ITER_W = $clog2(N + 1);

  logic [D-1:0]      rem;
  logic [D-1:0]      divr;
  logic [ITER_W-1:0] iter;

  logic [D:0] trial;
  logic [D:0] sub;
  logic       ge;

  assign trial = {rem, quotient[N-1]};
  assign sub   = trial - {1'b0, divr};
  assign ge    = trial >= {1'b0, divr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= ITER_W'(N);
    end else if (busy) begin
      iter <= iter - 1'b1;
      if (iter == ITER_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      divr     <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= ge ? sub[D-1:0] : trial[D-1:0];
      quotient <= {quotient[N-2:0], ge};
    end
  end

endmodule
`default_nettype wire

FILE: design/ssd_datapath.sv
// Datapath: config registers, position store, distance, frame sums, mean window, standby, output word.
`default_nettype none
module ssd_datapath
  import ssd_pkg::*;
#(
  parameter int JOINTS = JOINTS_DEF,
  parameter int WINDOW = WINDOW_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dp_cmd_t               cmd,
  output dp_st_t                     st,
  input  wire logic [JIDX_W-1:0]     joint_index,
  input  wire logic signed [POS_W-1:0] pos_x,
  input  wire logic signed [POS_W-1:0] pos_y,
  input  wire logic signed [POS_W-1:0] pos_z,
  input  wire logic                  last_joint,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  output logic [MEAN_W-1:0]          frame_mean,
  output logic [MEAN_W-1:0]          window_mean,
  output logic [CNT_W-1:0]           joints_counted,
  output logic                       still,
  output logic                       capture_trigger
);

  localparam int JA_W   = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int WA_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int WSH    = $clog2(WINDOW);
  localparam int WSUM_W = MEAN_W + WSH;
  localparam int RCP_SH = WSUM_W + WSH;
  localparam int RCP_W  = WSUM_W + 1;
  localparam longint unsigned RCP =
    ((64'd1 << RCP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam int PW3    = 3 * POS_W;

  // configuration
  logic [CFG_W-1:0]    joint_speed_limit;
  logic [CFG_W-1:0]    still_limit;
  logic [PERIOD_W-1:0] standby_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      joint_speed_limit <= JOINT_SPEED_LIMIT_RST;
      still_limit       <= STILL_LIMIT_RST;
      standby_period    <= STANDBY_PERIOD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_JOINT_SPEED_LIMIT: joint_speed_limit <= cfg_data;
        CFG_STILL_LIMIT:       still_limit       <= cfg_data;
        CFG_STANDBY_PERIOD:    standby_period    <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // latched input word
  logic [JIDX_W-1:0]       j_r;
  logic signed [POS_W-1:0] x_r, y_r, z_r;
  logic                    last_r;
  logic                    port_in_range;

  assign port_in_range = {1'b0, joint_index} < (JIDX_W + 1)'(JOINTS);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      j_r    <= joint_index;
      x_r    <= pos_x;
      y_r    <= pos_y;
      z_r    <= pos_z;
      last_r <= last_joint;
    end
  end

  // previous position store, entries read as zero until first written
  logic [PW3-1:0] pos_mem [JOINTS];
  logic [JOINTS-1:0] pos_vld;
  logic [PW3-1:0] pos_rd;
  logic           pos_rd_vld;
  logic [PW3-1:0] prev;

  always_ff @(posedge clk) begin
    if (cmd.pos_write) pos_mem[j_r[JA_W-1:0]] <= {x_r, y_r, z_r};
    if (cmd.load_in && port_in_range) pos_rd <= pos_mem[joint_index[JA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_vld    <= '0;
      pos_rd_vld <= 1'b0;
    end else begin
      if (cmd.pos_write) pos_vld[j_r[JA_W-1:0]] <= 1'b1;
      if (cmd.load_in)
        pos_rd_vld <= port_in_range && pos_vld[joint_index[JA_W-1:0]];
    end
  end

  assign prev = pos_rd_vld ? pos_rd : '0;

  // squared distance, one axis at a time through one multiplier
  logic signed [POS_W-1:0] cur_c, prv_c;
  logic signed [POS_W:0]   dlt;
  logic [POS_W:0]          neg;
  logic [POS_W-1:0]        mag_c;
  logic [POS_W-1:0]        mag_r;
  logic [SQ_W-1:0]         prod_r;
  logic [D2_W-1:0]         d2_r;

  always_comb begin
    unique case (cmd.axis)
      AXIS_X:  begin cur_c = x_r; prv_c = prev[PW3-1:2*POS_W];     end
      AXIS_Y:  begin cur_c = y_r; prv_c = prev[2*POS_W-1:POS_W];   end
      default: begin cur_c = z_r; prv_c = prev[POS_W-1:0];         end
    endcase
  end

  assign dlt   = {cur_c[POS_W-1], cur_c} - {prv_c[POS_W-1], prv_c};
  assign neg   = -dlt;
  assign mag_c = dlt[POS_W] ? neg[POS_W-1:0] : dlt[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.diff) mag_r <= mag_c;
    if (cmd.mul)  prod_r <= mag_r * mag_r;
    if (cmd.load_in)  d2_r <= '0;
    else if (cmd.acc) d2_r <= d2_r + {2'b00, prod_r};
  end

  logic              sqrt_busy;
  logic [ROOT_W-1:0] step;

  ssd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (d2_r),
    .busy     (sqrt_busy),
    .root     (step)
  );

  // frame mean divider
  logic             div_busy;
  logic [SUM_W-1:0] div_q;

  logic [SUM_W-1:0]  step_sum;
  logic [CNT_W-1:0]  count_below;
  logic [MEAN_W-1:0] held_mean;
  logic [WSUM_W-1:0] wsum;

  ssd_div #(
    .N (SUM_W),
    .D (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_step_start),
    .dividend (step_sum),
    .divisor  (count_below),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // mean window; a running sum saves walking the entries
  logic [MEAN_W-1:0] win_mem [WINDOW];
  logic [WINDOW-1:0] win_vld;
  logic [MEAN_W-1:0] win_rd;
  logic              win_rd_vld;
  logic [WA_W-1:0]   window_slot;
  logic [MEAN_W-1:0] old_mean;
  logic [WSUM_W:0]   wsum_next;

  always_ff @(posedge clk) begin
    if (cmd.win_update) win_mem[window_slot] <= held_mean;
    if (cmd.win_read)   win_rd <= win_mem[window_slot];
  end

  assign old_mean  = win_rd_vld ? win_rd : '0;
  assign wsum_next = {1'b0, wsum} + (WSUM_W + 1)'(held_mean) - (WSUM_W + 1)'(old_mean);

  // window sum / WINDOW by reciprocal multiply, exact for any sum the window holds
  logic [WSUM_W+RCP_W-1:0] wprod;
  logic [MEAN_W-1:0]       wmean;

  assign wprod = wsum * RCP_W'(RCP);

  always_ff @(posedge clk) begin
    if (cmd.win_mean) wmean <= wprod[RCP_SH +: MEAN_W];
  end

  // frame end decisions
  logic                still_c;
  logic [PERIOD_W-1:0] standby_count;
  logic [PERIOD_W-1:0] sb_inc;

  assign still_c = (wmean != '0) && (wmean <= still_limit);
  assign sb_inc  = standby_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_sum      <= '0;
      count_below   <= '0;
      held_mean     <= '0;
      wsum          <= '0;
      win_vld       <= '0;
      win_rd_vld    <= 1'b0;
      window_slot   <= '0;
      standby_count <= '0;
    end else begin
      if (cmd.step_update && (step < ROOT_W'(joint_speed_limit)) &&
          (count_below != CNT_MAX)) begin
        step_sum    <= step_sum + SUM_W'(step);
        count_below <= count_below + 1'b1;
      end
      if (cmd.hold_update && (count_below != '0)) held_mean <= div_q[MEAN_W-1:0];
      if (cmd.win_read) win_rd_vld <= win_vld[window_slot];
      if (cmd.win_update) begin
        wsum                 <= wsum_next[WSUM_W-1:0];
        win_vld[window_slot] <= 1'b1;
        if (window_slot == WA_W'(WINDOW - 1)) window_slot <= '0;
        else                                  window_slot <= window_slot + 1'b1;
      end
      if (cmd.finish) begin
        step_sum    <= '0;
        count_below <= '0;
        if (still_c) standby_count <= (sb_inc >= standby_period) ? '0 : sb_inc;
      end
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      frame_mean      <= held_mean;
      window_mean     <= wmean;
      joints_counted  <= count_below;
      still           <= still_c;
      capture_trigger <= still_c && (standby_count == '0);
    end
  end

  assign st.in_range   = {1'b0, j_r} < (JIDX_W + 1)'(JOINTS);
  assign st.last       = last_r;
  assign st.count_zero = count_below == '0;
  assign st.sqrt_busy  = sqrt_busy;
  assign st.div_busy   = div_busy;

endmodule
`default_nettype wire

FILE: design/ssd_ctrl.sv
// Controller: sequences one joint word and the frame close, owns the handshakes.
`default_nettype none
module ssd_ctrl
  import ssd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  wire logic   out_ready,
  input  wire dp_st_t st,
  output dp_cmd_t     cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIFF   = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_ACC    = 4'd3;
  localparam logic [3:0] S_SQST   = 4'd4;
  localparam logic [3:0] S_SQRT   = 4'd5;
  localparam logic [3:0] S_STEP   = 4'd6;
  localparam logic [3:0] S_FSTART = 4'd7;
  localparam logic [3:0] S_FDIV   = 4'd8;
  localparam logic [3:0] S_WRD    = 4'd9;
  localparam logic [3:0] S_WUPD   = 4'd10;
  localparam logic [3:0] S_WST    = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;

  logic [3:0] state, state_next;
  logic [1:0] axis, axis_next;
  logic       out_valid_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd        = '0;
    cmd.axis   = axis;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          axis_next   = AXIS_X;
          state_next  = S_DIFF;
        end
      end
      S_DIFF: begin
        if (!st.in_range) begin
          state_next = st.last ? S_FSTART : S_IDLE;
        end else begin
          cmd.diff   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (axis == AXIS_Z) begin
          state_next = S_SQST;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = S_DIFF;
        end
      end
      S_SQST: begin
        cmd.sqrt_start = 1'b1;
        cmd.pos_write  = 1'b1;
        state_next     = S_SQRT;
      end
      S_SQRT: begin
        if (!st.sqrt_busy) state_next = S_STEP;
      end
      S_STEP: begin
        cmd.step_update = 1'b1;
        state_next      = st.last ? S_FSTART : S_IDLE;
      end
      S_FSTART: begin
        if (st.count_zero) begin
          state_next = S_WRD;
        end else begin
          cmd.div_step_start = 1'b1;
          state_next         = S_FDIV;
        end
      end
      S_FDIV: begin
        if (!st.div_busy) state_next = S_WRD;
      end
      S_WRD: begin
        cmd.hold_update = 1'b1;
        cmd.win_read    = 1'b1;
        state_next      = S_WUPD;
      end
      S_WUPD: begin
        cmd.win_update = 1'b1;
        state_next     = S_WST;
      end
      S_WST: begin
        cmd.win_mean = 1'b1;
        state_next   = S_FIN;
      end
      S_FIN: begin
        // hold here while the previous result word is still waiting
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= AXIS_X;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/skeleton_stillness_detector_core.sv
// Top level: skeleton stillness detector, controller plus datapath.
//
// One input word is one joint position; a result word leaves only on a word
// marked last_joint. A joint in range runs, between acceptance and the return
// of in_ready, three abs-difference/multiply/accumulate passes through one
// 24x24 multiplier, then the 25-step bit-serial square root. An out-of-range
// joint skips that work. A frame-closing word adds the 25-step bit-serial
// frame mean divide when a joint was counted and skips it when none was; the
// window mean is a single reciprocal multiply. The result sits in an output
// register so the next joint is taken while it waits; only a second frame
// close stalls on it. Stored positions and window entries read as zero until
// written (valid bits), so no clearing pass runs.
`default_nettype none
module skeleton_stillness_detector_core
  import ssd_pkg::*;
#(
  parameter int JOINTS = JOINTS_DEF,
  parameter int WINDOW = WINDOW_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [JIDX_W-1:0]       joint_index,
  input  wire logic signed [POS_W-1:0] pos_x,
  input  wire logic signed [POS_W-1:0] pos_y,
  input  wire logic signed [POS_W-1:0] pos_z,
  input  wire logic                    last_joint,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [MEAN_W-1:0]            frame_mean,
  output logic [MEAN_W-1:0]            window_mean,
  output logic [CNT_W-1:0]             joints_counted,
  output logic                         still,
  output logic                         capture_trigger,
  input  wire logic                    cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data
);

  dp_cmd_t cmd;
  dp_st_t  st;

  ssd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  ssd_datapath #(
    .JOINTS (JOINTS),
    .WINDOW (WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .joint_index     (joint_index),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pos_z           (pos_z),
    .last_joint      (last_joint),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .frame_mean      (frame_mean),
    .window_mean     (window_mean),
    .joints_counted  (joints_counted),
    .still           (still),
    .capture_trigger (capture_trigger)
  );

  // a new word is never accepted while an iterative unit is still running
  a_accept_units_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !st.sqrt_busy && !st.div_busy)
    else $error("word accepted while sqrt or divider busy");

  a_trigger_needs_still: assert property (@(posedge clk) disable iff (rst)
    out_valid && capture_trigger |-> still)
    else $error("capture trigger without still");

  a_still_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && still |-> window_mean != '0)
    else $error("still flagged with zero window mean");

  // the frame close only loads the output word when the slot is free
  a_finish_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !out_valid || out_ready)
    else $error("result word overwritten before it was taken");

endmodule
`default_nettype wire
